/* design/usg_pkg.sv */
package usg_pkg;

   localparam int MAX_UPSAMPLE_DEF = 64;
   localparam int PHASE_BITS_DEF   = 32;
   localparam int SAMPLE_BITS_DEF  = 16;

   localparam logic [6:0]  UPSAMPLE_RESET   = 7'd64;
   localparam logic [31:0] FREQ_SCALE_RESET = 32'd12466055;

   localparam logic CSR_UPSAMPLE   = 1'b0;
   localparam logic CSR_FREQ_SCALE = 1'b1;

   localparam logic KIND_PITCH = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   localparam logic signed [31:0] C1 = 32'sd1686629713;
   localparam logic signed [31:0] C3 = -32'sd693598668;
   localparam logic signed [31:0] C5 = 32'sd85569306;
   localparam logic signed [31:0] C7 = -32'sd5026995;
   localparam logic signed [31:0] C9 = 32'sd172272;

   typedef struct packed {
      logic        run;
      logic [47:0] s0;
      logic [47:0] s1;
   } frame_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_RUN
   } back_state_type;

   typedef enum logic [3:0] {
      SN_IDLE, SN_T2, SN_P7, SN_P5, SN_P3, SN_P1, SN_S, SN_M, SN_OUT
   } sine_state_type;

endpackage

/* design/usg_front.sv */
module usg_front #(
   parameter int PHASE_BITS = usg_pkg::PHASE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic [15:0]           req_f0,
   input  logic [31:0]           freq_scale,
   output logic                  q_valid,
   input  logic                  q_stall,
   output usg_pkg::frame_type    q_frame,
   output logic                  q_flush
);
   // stage 1: register product of new frame; stage 2: pair with pending
   logic              pend_valid_ff, pend_valid_in;
   logic [15:0]       pend_f0_ff, pend_f0_in;
   logic              s1v_ff, s1v_in;
   logic              s1kind_ff;
   logic [47:0]       s1inc_ff;
   logic [15:0]       s1f0_ff;
   logic              q_valid_ff, q_valid_in;
   usg_pkg::frame_type q_frame_ff, q_frame_in;
   logic              q_flush_ff, q_flush_in;
   logic              s1_take;
   logic [47:0]       prod;
   logic [47:0]       pend_prod;
   logic [47:0]       pend_inc;

   assign prod = 48'(req_f0) * 48'(freq_scale);
   // pending increment uses the scale in force when the frame is emitted
   assign pend_prod = 48'(pend_f0_ff) * 48'(freq_scale);
   assign pend_inc  = 48'(pend_prod >> (40 - PHASE_BITS));
   // stage 1 moves to 2 when output slot free or will free
   assign s1_take   = s1v_ff && (!q_valid_ff || !q_stall);
   assign req_stall = s1v_ff && !s1_take;
   assign q_valid = q_valid_ff;
   assign q_frame = q_frame_ff;
   assign q_flush = q_flush_ff;

   always_comb begin
      s1v_in        = s1v_ff;
      pend_valid_in = pend_valid_ff;
      pend_f0_in    = pend_f0_ff;
      q_valid_in    = q_valid_ff && q_stall;
      q_frame_in    = q_frame_ff;
      q_flush_in    = q_flush_ff;
      if (s1_take) begin
         s1v_in = 1'b0;
         if (pend_valid_ff) begin
            q_valid_in   = 1'b1;
            q_frame_in.run = 1'b1;
            q_frame_in.s0 = pend_inc;
            q_frame_in.s1 = (s1kind_ff == usg_pkg::KIND_FLUSH) ? pend_inc : s1inc_ff;
            q_flush_in   = s1kind_ff;
         end else if (s1kind_ff == usg_pkg::KIND_FLUSH) begin
            q_valid_in = 1'b1;
            q_frame_in = '0;
            q_flush_in = 1'b1;
         end
         pend_valid_in = (s1kind_ff == usg_pkg::KIND_PITCH);
         pend_f0_in    = s1f0_ff;
      end
      if (req_valid && !req_stall)
         s1v_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1v_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         q_valid_ff    <= 1'b0;
      end else begin
         s1v_ff        <= s1v_in;
         pend_valid_ff <= pend_valid_in;
         q_valid_ff    <= q_valid_in;
      end
      pend_f0_ff  <= pend_f0_in;
      q_frame_ff  <= q_frame_in;
      q_flush_ff  <= q_flush_in;
      if (req_valid && !req_stall) begin
         s1kind_ff <= req_kind;
         s1f0_ff   <= req_f0;
         s1inc_ff  <= 48'(prod >> (40 - PHASE_BITS));
      end
   end
endmodule

/* design/usg_sine.sv */
module usg_sine #(
   parameter int PHASE_BITS  = usg_pkg::PHASE_BITS_DEF,
   parameter int SAMPLE_BITS = usg_pkg::SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [PHASE_BITS-1:0]  phase,
   output logic                   busy,
   output logic                   done,
   output logic [15:0]            result
);
   localparam logic [63:0] AMP = 64'((64'd1 << (SAMPLE_BITS - 1)) - 1);

   usg_pkg::sine_state_type st_ff, st_in;
   logic [1:0]          quad_ff;
   logic [30:0]         t_ff;
   logic [30:0]         t2_ff;
   logic signed [32:0]  p_ff, p_in;
   logic [15:0]         res_ff;
   logic [15:0]         p16;
   logic [14:0]         x;
   logic [32:0]         pmag;
   logic [30:0]         mulb;
   logic [63:0]         prod;
   logic signed [32:0]  mq;
   logic signed [31:0]  coef;
   logic [63:0]         mscaled;
   logic [63:0]         m;

   assign p16 = phase[PHASE_BITS-1 -: 16];
   assign x   = p16[14] ? 15'(15'd16384 - 15'(p16[13:0])) : 15'(p16[13:0]);

   always_comb begin
      mulb = (st_ff == usg_pkg::SN_T2 || st_ff == usg_pkg::SN_S) ? t_ff : t2_ff;
      pmag = (st_ff == usg_pkg::SN_T2) ? 33'(t_ff) : (p_ff[32] ? 33'(-p_ff) : 33'(p_ff));
      prod = 64'(pmag) * 64'(mulb);
      mq   = p_ff[32] && st_ff != usg_pkg::SN_T2 ? -33'(prod >> 30) : 33'(prod >> 30);
      unique case (st_ff)
         usg_pkg::SN_P7: coef = usg_pkg::C7;
         usg_pkg::SN_P5: coef = usg_pkg::C5;
         usg_pkg::SN_P3: coef = usg_pkg::C3;
         default:        coef = usg_pkg::C1;
      endcase
      mscaled = 64'(p_ff[31:0]) * AMP + (64'd1 << 29);
      m = mscaled >> 30;
      if (m > AMP) m = AMP;
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         usg_pkg::SN_IDLE: if (start) st_in = usg_pkg::SN_T2;
         usg_pkg::SN_T2:   st_in = usg_pkg::SN_P7;
         usg_pkg::SN_P7:   st_in = usg_pkg::SN_P5;
         usg_pkg::SN_P5:   st_in = usg_pkg::SN_P3;
         usg_pkg::SN_P3:   st_in = usg_pkg::SN_P1;
         usg_pkg::SN_P1:   st_in = usg_pkg::SN_S;
         usg_pkg::SN_S:    st_in = usg_pkg::SN_M;
         usg_pkg::SN_M:    st_in = usg_pkg::SN_OUT;
         usg_pkg::SN_OUT:  st_in = usg_pkg::SN_IDLE;
         default:          st_in = usg_pkg::SN_IDLE;
      endcase
   end

   always_comb begin
      p_in = p_ff;
      unique case (st_ff)
         usg_pkg::SN_T2: p_in = 33'(usg_pkg::C9);
         usg_pkg::SN_P7, usg_pkg::SN_P5, usg_pkg::SN_P3, usg_pkg::SN_P1:
            p_in = 33'(coef) + mq;
         usg_pkg::SN_S: p_in = mq[32] ? 33'sd0 : mq;
         default: p_in = p_ff;
      endcase
   end

   assign busy   = (st_ff != usg_pkg::SN_IDLE);
   assign done   = (st_ff == usg_pkg::SN_OUT);
   assign result = res_ff;

   always_ff @(posedge clock) begin
      if (reset) st_ff <= usg_pkg::SN_IDLE;
      else       st_ff <= st_in;
      p_ff <= p_in;
      if (st_ff == usg_pkg::SN_IDLE && start) begin
         quad_ff <= p16[15:14];
         t_ff    <= {x, 16'd0};
      end
      if (st_ff == usg_pkg::SN_T2) t2_ff <= 31'(prod >> 30);
      if (st_ff == usg_pkg::SN_M)
         res_ff <= quad_ff[1] ? 16'(-m) : 16'(m);
   end
endmodule

/* design/usg_back.sv */
module usg_back #(
   parameter int MAX_UPSAMPLE = usg_pkg::MAX_UPSAMPLE_DEF,
   parameter int PHASE_BITS   = usg_pkg::PHASE_BITS_DEF,
   parameter int SAMPLE_BITS  = usg_pkg::SAMPLE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [6:0]         upsample,
   input  logic               q_valid,
   output logic               q_stall,
   input  usg_pkg::frame_type q_frame,
   input  logic               q_flush,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_sample,
   output logic               rsp_last_in_run
);
   usg_pkg::back_state_type st_ff, st_in;
   logic [PHASE_BITS-1:0] phase_ff;
   logic [PHASE_BITS-1:0] phase_next;
   logic [47:0]  s0_ff;
   logic [48:0]  ds_ff;       // magnitude, shifted out from the top during divide
   logic         neg_ff;
   logic [48:0]  dq_ff;
   logic [6:0]   dr_ff;
   logic [6:0]   u_ff;
   logic [5:0]   bit_ff;
   logic [48:0]  rq_ff;
   logic [6:0]   rr_ff;
   logic [6:0]   n_ff;
   logic         flush_ff;
   logic         sine_wait_ff;
   logic         ov_ff;
   logic [15:0]  ov_smp_ff;
   logic         ov_last_ff;
   logic         sine_start, sine_busy, sine_done;
   logic [15:0]  sine_res;
   logic [6:0]   u_sat;
   logic [48:0]  ds;
   logic [48:0]  rem;
   logic [48:0]  trial;
   logic [48:0]  dqf;
   logic [6:0]   drf;
   logic [48:0]  inc;
   logic [7:0]   rr_sum;

   always_comb begin
      if (upsample == 7'd0) u_sat = 7'd1;
      else if (32'(upsample) > MAX_UPSAMPLE) u_sat = 7'(MAX_UPSAMPLE);
      else u_sat = upsample;
   end

   assign ds = 49'(q_frame.s1) - 49'(q_frame.s0);
   // restoring division: dividend bits shift out of ds_ff top into the remainder
   assign rem   = {42'd0, dr_ff};
   assign trial = {rem[47:0], ds_ff[48]};
   // floor quotient/remainder from magnitude division
   always_comb begin
      if (!neg_ff || dr_ff == 7'd0) begin
         dqf = neg_ff ? -dq_ff : dq_ff;
         drf = dr_ff;
      end else begin
         dqf = -(dq_ff + 49'd1);
         drf = 7'(u_ff - dr_ff);
      end
   end

   assign inc    = 49'(s0_ff) + rq_ff;
   assign phase_next = PHASE_BITS'(49'(phase_ff) + inc);
   assign rr_sum = 8'(rr_ff) + 8'(drf);
   assign q_stall = (st_ff != usg_pkg::ST_IDLE);
   assign sine_start = (st_ff == usg_pkg::ST_RUN) && !sine_wait_ff && !ov_ff && !sine_busy;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         usg_pkg::ST_IDLE:
            if (q_valid) st_in = q_flush && !q_frame.run ? usg_pkg::ST_IDLE : usg_pkg::ST_DIV;
         usg_pkg::ST_DIV:
            if (bit_ff == 6'd0) st_in = usg_pkg::ST_RUN;
         usg_pkg::ST_RUN:
            if (ov_ff && !rsp_stall && ov_last_ff) st_in = usg_pkg::ST_IDLE;
         default: st_in = usg_pkg::ST_IDLE;
      endcase
   end

   usg_sine #(.PHASE_BITS(PHASE_BITS), .SAMPLE_BITS(SAMPLE_BITS)) u_sine (
      .clock(clock), .reset(reset), .start(sine_start), .phase(phase_next),
      .busy(sine_busy), .done(sine_done), .result(sine_res)
   );

   assign rsp_valid       = ov_ff;
   assign rsp_sample      = ov_smp_ff;
   assign rsp_last_in_run = ov_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= usg_pkg::ST_IDLE;
         phase_ff     <= '0;
         ov_ff        <= 1'b0;
         sine_wait_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         unique case (st_ff)
            usg_pkg::ST_IDLE: begin
               if (q_valid) begin
                  s0_ff    <= q_frame.s0;
                  neg_ff   <= ds[48];
                  ds_ff    <= ds[48] ? -ds : ds;
                  dq_ff    <= '0;
                  dr_ff    <= '0;
                  u_ff     <= u_sat;
                  bit_ff   <= 6'd48;
                  flush_ff <= q_flush;
                  if (q_flush && !q_frame.run) phase_ff <= '0;
               end
            end
            usg_pkg::ST_DIV: begin
               ds_ff  <= {ds_ff[47:0], 1'b0};
               if (trial >= 49'(u_ff)) begin
                  dr_ff <= 7'(trial - 49'(u_ff));
                  dq_ff <= {dq_ff[47:0], 1'b1};
               end else begin
                  dr_ff <= 7'(trial);
                  dq_ff <= {dq_ff[47:0], 1'b0};
               end
               bit_ff <= bit_ff - 6'd1;
               rq_ff  <= '0;
               rr_ff  <= '0;
               n_ff   <= 7'd1;
            end
            usg_pkg::ST_RUN: begin
               if (sine_start) begin
                  phase_ff     <= phase_next;
                  sine_wait_ff <= 1'b1;
               end
               if (sine_done) begin
                  sine_wait_ff <= 1'b0;
                  ov_ff        <= 1'b1;
                  ov_smp_ff    <= sine_res;
                  ov_last_ff   <= (n_ff == u_ff);
                  n_ff         <= n_ff + 7'd1;
                  if (rr_sum >= 8'(u_ff)) begin
                     rr_ff <= 7'(rr_sum - 8'(u_ff));
                     rq_ff <= rq_ff + dqf + 49'd1;
                  end else begin
                     rr_ff <= 7'(rr_sum);
                     rq_ff <= rq_ff + dqf;
                  end
               end
               if (ov_ff && !rsp_stall) begin
                  ov_ff <= 1'b0;
                  if (ov_last_ff && flush_ff) phase_ff <= '0;
               end
            end
            default: ;
         endcase
      end
   end
endmodule

/* design/upsampled_sine_excitation_generator.sv */
// Upsampled sine excitation generator.
// Input channel (req_valid/req_stall, req_kind, req_f0): one transaction per
// pitch frame (kind 0) or flush (kind 1). A pitch frame is held until the
// next transaction arrives; then the held frame yields upsample samples on
// the rsp channel, ramping its phase increment linearly toward the new one.
// A flush emits the held frame with a flat ramp and zeroes the phase.
// Result channel (rsp_valid/rsp_stall, rsp_sample, rsp_last_in_run): one
// transaction per sample; last_in_run marks the frame's final sample.
// Datapath: the front registers and pairs frames, the back runs a
// restoring ramp divider, then computes each sample in turn on the
// multi-cycle sine polynomial unit.
// A one-deep queue lets the front accept the next transaction while the
// back is busy. A stalled result holds; the sine unit waits for it.
// Reset (synchronous, active high) clears the held frame and the phase
// and restores upsample = 64, freq_scale = 12466055.
// csr_write with csr_index 0 (upsample) or 1 (freq_scale); only when idle.
module upsampled_sine_excitation_generator #(
   parameter int MAX_UPSAMPLE = usg_pkg::MAX_UPSAMPLE_DEF,
   parameter int PHASE_BITS   = usg_pkg::PHASE_BITS_DEF,
   parameter int SAMPLE_BITS  = usg_pkg::SAMPLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [15:0] req_f0,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_sample,
   output logic        rsp_last_in_run
);
   logic [6:0]  upsample_ff;
   logic [31:0] freq_scale_ff;
   logic        q_valid, q_stall, q_flush;
   usg_pkg::frame_type q_frame;

   always_ff @(posedge clock) begin
      if (reset) begin
         upsample_ff   <= usg_pkg::UPSAMPLE_RESET;
         freq_scale_ff <= usg_pkg::FREQ_SCALE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            usg_pkg::CSR_UPSAMPLE:   upsample_ff   <= csr_data[6:0];
            usg_pkg::CSR_FREQ_SCALE: freq_scale_ff <= csr_data;
            default: ;
         endcase
      end
   end

   usg_front #(.PHASE_BITS(PHASE_BITS)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .req_f0(req_f0), .freq_scale(freq_scale_ff),
      .q_valid(q_valid), .q_stall(q_stall), .q_frame(q_frame), .q_flush(q_flush)
   );

   usg_back #(.MAX_UPSAMPLE(MAX_UPSAMPLE), .PHASE_BITS(PHASE_BITS),
              .SAMPLE_BITS(SAMPLE_BITS)) u_back (
      .clock(clock), .reset(reset), .upsample(upsample_ff),
      .q_valid(q_valid), .q_stall(q_stall), .q_frame(q_frame), .q_flush(q_flush),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_sample(rsp_sample),
      .rsp_last_in_run(rsp_last_in_run)
   );
endmodule

/* test/upsampled_sine_excitation_generator_test.sv */
`timescale 1ns / 1ps

module upsampled_sine_excitation_generator_test;

   typedef struct {
      logic [15:0] sample;
      logic        last_in_run;
   } sample_type;

   class sine_scoreboard;
      logic [6:0]  upsample;
      logic [31:0] freq_scale;
      logic [31:0] phase;
      logic [15:0] held_f0;
      bit          held;
      sample_type  pending_samples[$];
      int          errors;

      function new();
         upsample = usg_pkg::UPSAMPLE_RESET;
         freq_scale = usg_pkg::FREQ_SCALE_RESET;
         phase = 0;
         held_f0 = 0;
         held = 0;
         errors = 0;
      endfunction

      function longint mul_trunc(longint a, longint b);
         longint mag;
         longint p;
         mag = (a < 0) ? -a : a;
         p = (mag * b) >>> 30;
         return (a < 0) ? -p : p;
      endfunction

      function logic [15:0] sine_of(logic [31:0] ph);
         logic [15:0] p16;
         longint x, t, t2, p, s, m;
         longint c[5];
         c[0] = usg_pkg::C1; c[1] = usg_pkg::C3; c[2] = usg_pkg::C5;
         c[3] = usg_pkg::C7; c[4] = usg_pkg::C9;
         p16 = ph[31:16];
         x = p16[13:0];
         if (p16[14]) x = 16384 - x;
         t = x << 16;
         t2 = (t * t) >>> 30;
         p = c[4];
         for (int i = 3; i >= 0; i--) p = c[i] + mul_trunc(p, t2);
         s = mul_trunc(p, t);
         if (s < 0) s = 0;
         m = (s * 32767 + (64'sd1 << 29)) >>> 30;
         if (m > 32767) m = 32767;
         if (p16[15]) m = -m;
         return m[15:0];
      endfunction

      function longint increment_of(logic [15:0] f);
         longint prod;
         prod = longint'({16'd0, f}) * longint'({32'd0, freq_scale});
         return prod >>> 8;
      endfunction

      function void emit_run(longint s0, longint s1);
         longint u, ds, dq, dr, q, r;
         sample_type e;
         u = upsample;
         if (u < 1) u = 1;
         if (u > 64) u = 64;
         ds = s1 - s0;
         if (ds >= 0) dq = ds / u;
         else dq = -((-ds + u - 1) / u);
         dr = ds - dq * u;
         q = 0;
         r = 0;
         for (longint n = 1; n <= u; n++) begin
            phase = phase + 32'(s0 + q);
            e.sample = sine_of(phase);
            e.last_in_run = (n == u);
            pending_samples.push_back(e);
            q += dq;
            r += dr;
            if (r >= u) begin
               r -= u;
               q += 1;
            end
         end
      endfunction

      function void note_transaction(logic kind, logic [15:0] f0);
         if (kind == usg_pkg::KIND_PITCH) begin
            if (held) emit_run(increment_of(held_f0), increment_of(f0));
            held_f0 = f0;
            held = 1;
         end else begin
            if (held) emit_run(increment_of(held_f0), increment_of(held_f0));
            held = 0;
            held_f0 = 0;
            phase = 0;
         end
      endfunction

      function void check_sample(logic [15:0] sample, logic last_in_run);
         sample_type e;
         if (pending_samples.size() == 0) begin
            $error("unexpected sample %0d", $signed(sample));
            errors++;
            return;
         end
         e = pending_samples.pop_front();
         if (sample !== e.sample) begin
            $error("sample expected %0d actual %0d", $signed(e.sample), $signed(sample));
            errors++;
         end
         if (last_in_run !== e.last_in_run) begin
            $error("last_in_run expected %0d actual %0d", e.last_in_run, last_in_run);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic        csr_index;
   logic [31:0] csr_data;
   logic        req_valid;
   logic        req_stall;
   logic        req_kind;
   logic [15:0] req_f0;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_sample;
   logic        rsp_last_in_run;

   sine_scoreboard board;
   int send_idle_pct;
   int stall_pct;
   int hold_off_cycles;

   upsampled_sine_excitation_generator dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .req_f0(req_f0),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_sample(rsp_sample), .rsp_last_in_run(rsp_last_in_run)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("simulation failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_sample(rsp_sample, rsp_last_in_run);
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_item(logic kind, logic [15:0] f0);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_kind <= kind;
      req_f0 <= f0;
      do @(posedge clock); while (req_stall);
      board.note_transaction(kind, f0);
   endtask

   task automatic write_csr(logic index, logic [31:0] value);
      csr_write <= 1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 0;
      if (index == usg_pkg::CSR_UPSAMPLE) board.upsample = value[6:0];
      else board.freq_scale = value;
      @(posedge clock);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 0;
      while (board.pending_samples.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (800) @(posedge clock);
   endtask

   task automatic random_sequence(int frames);
      logic [15:0] base;
      base = 16'($urandom_range(65535));
      for (int i = 0; i < frames; i++) begin
         if ($urandom_range(9) == 0) send_item(usg_pkg::KIND_PITCH, 16'($urandom));
         else send_item(usg_pkg::KIND_PITCH, base + 16'($urandom_range(400)) - 16'd200);
      end
      if ($urandom_range(3) != 0) send_item(usg_pkg::KIND_FLUSH, 16'($urandom));
   endtask

   task automatic set_idling(int phase_no);
      case (phase_no % 4)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 85; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 85; end
         default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
   endtask

   initial begin
      int sent;
      logic [6:0] ups[6];
      logic [31:0] scales[6];
      board = new();
      reset = 1;
      csr_write = 0;
      csr_index = usg_pkg::CSR_UPSAMPLE;
      csr_data = 0;
      req_valid = 0;
      req_kind = usg_pkg::KIND_PITCH;
      req_f0 = 0;
      rsp_stall = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off_cycles = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: default freq_scale, extremes, flush cases
      write_csr(usg_pkg::CSR_UPSAMPLE, 4);
      send_item(usg_pkg::KIND_FLUSH, 16'hFFFF);
      send_item(usg_pkg::KIND_PITCH, 16'hFFFF);
      send_item(usg_pkg::KIND_PITCH, 0);
      send_item(usg_pkg::KIND_PITCH, 16'hFFFF);
      send_item(usg_pkg::KIND_PITCH, 16'h5555);
      send_item(usg_pkg::KIND_PITCH, 16'hAAAA);
      send_item(usg_pkg::KIND_FLUSH, 0);
      send_item(usg_pkg::KIND_FLUSH, 0);
      drain();
      write_csr(usg_pkg::CSR_UPSAMPLE, 0);
      write_csr(usg_pkg::CSR_FREQ_SCALE, 32'hFFFF_FFFF);
      send_item(usg_pkg::KIND_PITCH, 16'h8000);
      send_item(usg_pkg::KIND_PITCH, 16'h0001);
      send_item(usg_pkg::KIND_PITCH, 16'hFFFF);
      send_item(usg_pkg::KIND_FLUSH, 0);
      drain();
      write_csr(usg_pkg::CSR_UPSAMPLE, 7'h7F);
      write_csr(usg_pkg::CSR_FREQ_SCALE, 0);
      send_item(usg_pkg::KIND_PITCH, 16'h1234);
      send_item(usg_pkg::KIND_FLUSH, 0);
      drain();
      write_csr(usg_pkg::CSR_UPSAMPLE, 64);
      write_csr(usg_pkg::CSR_FREQ_SCALE, 1);
      send_item(usg_pkg::KIND_PITCH, 16'hFFFF);
      send_item(usg_pkg::KIND_PITCH, 0);
      send_item(usg_pkg::KIND_FLUSH, 0);
      drain();

      // long receiver hold-off while the sender keeps going
      write_csr(usg_pkg::CSR_UPSAMPLE, 3);
      write_csr(usg_pkg::CSR_FREQ_SCALE, usg_pkg::FREQ_SCALE_RESET);
      hold_off_cycles = 600;
      for (int i = 0; i < 8; i++) send_item(usg_pkg::KIND_PITCH, 16'($urandom));
      send_item(usg_pkg::KIND_FLUSH, 0);
      drain();

      ups = '{1, 2, 5, 13, 64, 8};
      scales = '{usg_pkg::FREQ_SCALE_RESET, 32'hFFFF_FFFF, 1, 32'h0100_0000,
                 32'h8000_0000, 32'd999};
      sent = 0;
      for (int ph = 0; sent < 220; ph++) begin
         set_idling(ph);
         write_csr(usg_pkg::CSR_UPSAMPLE,
                   (ph % 3 == 0) ? ups[ph % 6] : 7'($urandom_range(1, 12)));
         write_csr(usg_pkg::CSR_FREQ_SCALE, (ph % 2 == 0) ? scales[ph % 6] : $urandom);
         for (int k = 0; k < 3; k++) begin
            int frames;
            frames = $urandom_range(2, 8);
            random_sequence(frames);
            sent += frames + 1;
         end
         drain();
      end

      if (board.errors == 0 && board.pending_samples.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
